>>> sv/uart_power_command_parser_macros.svh
// Assertion macros for the power command parser.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef UART_POWER_COMMAND_PARSER_MACROS_SVH
`define UART_POWER_COMMAND_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define UCP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define UCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ucp_pkg.sv
// Shared types, character constants and text lookups for the power command parser.
// No dependencies.
package ucp_pkg;

    // Parser phase: wait for 'b', 't', ':' or inside the command body
    typedef enum logic [1:0] {
        PH_B     = 2'd0,
        PH_T     = 2'd1,
        PH_COLON = 2'd2,
        PH_BODY  = 2'd3
    } phase_t;

    // Reply attached to a link byte
    typedef enum logic [1:0] {
        REPLY_NONE = 2'd0,
        REPLY_ON   = 2'd1,
        REPLY_OFF  = 2'd2
    } reply_t;

    // One classified request handed from the front to the back
    typedef struct packed {
        logic       host;    // 1: byte from host, forward to link
        logic [7:0] data;    // received byte
        reply_t     reply;   // reply to send before the echo
        logic       power;   // power level after this request
    } ucp_cmd_t;

    localparam logic [7:0] CHAR_B     = 8'h62;
    localparam logic [7:0] CHAR_T     = 8'h74;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;

    localparam int CMD_ON_LEN  = 11;
    localparam int CMD_OFF_LEN = 12;
    localparam int QUEUE_DEPTH = 4;

    // Character of "bt:power=on" (off = 0) or "bt:power=off" (off = 1)
    function automatic logic [7:0] cmd_char(input logic off, input logic [3:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                4'd0:    c = 8'h62; // b
                4'd1:    c = 8'h74; // t
                4'd2:    c = 8'h3a; // :
                4'd3:    c = 8'h70; // p
                4'd4:    c = 8'h6f; // o
                4'd5:    c = 8'h77; // w
                4'd6:    c = 8'h65; // e
                4'd7:    c = 8'h72; // r
                4'd8:    c = 8'h3d; // =
                4'd9:    c = 8'h6f; // o
                4'd10:   c = off ? 8'h66 : 8'h6e; // f or n
                4'd11:   c = 8'h66; // f
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // Number of reply bytes for a reply kind
    function automatic logic [2:0] reply_len(input reply_t r);
        logic [2:0] n;
        begin
            case (r)
                REPLY_ON:  n = 3'd4;
                REPLY_OFF: n = 3'd5;
                default:   n = 3'd0;
            endcase
            return n;
        end
    endfunction

    // Reply text: "On\r\n" or "Off\r\n"
    function automatic logic [7:0] reply_char(input reply_t r, input logic [2:0] idx);
        logic [7:0] c;
        begin
            if (r == REPLY_OFF) begin
                case (idx)
                    3'd0:    c = 8'h4f;
                    3'd1:    c = 8'h66;
                    3'd2:    c = 8'h66;
                    3'd3:    c = 8'h0d;
                    default: c = 8'h0a;
                endcase
            end
            else begin
                case (idx)
                    3'd0:    c = 8'h4f;
                    3'd1:    c = 8'h6e;
                    3'd2:    c = 8'h0d;
                    default: c = 8'h0a;
                endcase
            end
            return c;
        end
    endfunction

endpackage

>>> sv/ucp_front.sv
// Front end: accepts received bytes, runs the line parser and classifies each request.
// Depends on ucp_pkg. Feeds ucp_queue.
module ucp_front #(
    parameter int LINE_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_source,
    input  logic [7:0]        in_byte,
    input  logic              q_full,
    output logic              push,
    output ucp_pkg::ucp_cmd_t push_cmd
);
    import ucp_pkg::*;

    localparam int FillW = $clog2(LINE_DEPTH + 1);

    phase_t           phase_reg, phase_next;
    logic [FillW-1:0] fill_reg, fill_next;
    logic             too_long_reg, too_long_next;
    logic             on_ok_reg, on_ok_next;
    logic             off_ok_reg, off_ok_next;
    logic             power_reg, power_next;

    logic             restart;
    logic             line_reset;
    logic             base_on, base_off;
    logic [FillW-1:0] idx;
    reply_t           reply;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // Parse one link byte: phase, line tracking and command match
    always_comb
    begin
        phase_next    = phase_reg;
        fill_next     = fill_reg;
        too_long_next = too_long_reg;
        on_ok_next    = on_ok_reg;
        off_ok_next   = off_ok_reg;
        power_next    = power_reg;
        restart       = 1'b0;
        reply         = REPLY_NONE;

        unique case (phase_reg)
            PH_B:
            begin
                if (in_byte == CHAR_B)
                    phase_next = PH_T;
                else
                    restart = 1'b1;
            end
            PH_T:
            begin
                if (in_byte == CHAR_T)
                    phase_next = PH_COLON;
                else
                    restart = 1'b1;
            end
            PH_COLON:
            begin
                if (in_byte == CHAR_COLON)
                    phase_next = PH_BODY;
                else
                    restart = 1'b1;
            end
            PH_BODY:
            begin
                if (in_byte == CHAR_CR || in_byte == CHAR_LF)
                begin
                    restart = 1'b1;
                    if (!too_long_reg && on_ok_reg && fill_reg == FillW'(CMD_ON_LEN))
                    begin
                        reply      = REPLY_ON;
                        power_next = 1'b1;
                    end
                    else if (!too_long_reg && off_ok_reg
                             && fill_reg == FillW'(CMD_OFF_LEN))
                    begin
                        reply      = REPLY_OFF;
                        power_next = 1'b0;
                    end
                end
            end
            default:
            begin
                restart = 1'b1;
            end
        endcase

        if (restart)
            phase_next = (in_byte == CHAR_B) ? PH_T : PH_B;

        // Restart the line in phase 0 and on every restart, then append the byte
        line_reset = restart || (phase_reg == PH_B);
        idx        = line_reset ? '0 : fill_reg;
        base_on    = line_reset ? 1'b1 : on_ok_reg;
        base_off   = line_reset ? 1'b1 : off_ok_reg;
        if (line_reset)
            too_long_next = 1'b0;

        if (idx < FillW'(LINE_DEPTH))
        begin
            fill_next   = idx + FillW'(1);
            on_ok_next  = base_on && (idx < FillW'(CMD_ON_LEN))
                          && (in_byte == cmd_char(1'b0, idx[3:0]));
            off_ok_next = base_off && (idx < FillW'(CMD_OFF_LEN))
                          && (in_byte == cmd_char(1'b1, idx[3:0]));
        end
        else
        begin
            fill_next     = idx;
            too_long_next = 1'b1;
        end
    end

    // Build the request for the queue
    always_comb
    begin
        push_cmd.host  = in_source;
        push_cmd.data  = in_byte;
        push_cmd.reply = in_source ? REPLY_NONE : reply;
        push_cmd.power = in_source ? power_reg : power_next;
    end

    // Advance parser state on accepted link bytes only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_B;
            fill_reg     <= '0;
            too_long_reg <= 1'b0;
            on_ok_reg    <= 1'b0;
            off_ok_reg   <= 1'b0;
            power_reg    <= 1'b0;
        end
        else if (push && !in_source)
        begin
            phase_reg    <= phase_next;
            fill_reg     <= fill_next;
            too_long_reg <= too_long_next;
            on_ok_reg    <= on_ok_next;
            off_ok_reg   <= off_ok_next;
            power_reg    <= power_next;
        end
    end

endmodule

>>> sv/ucp_queue.sv
// Short request queue between the parser front and the transmit back end.
// Depends on ucp_pkg.
module ucp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ucp_pkg::ucp_cmd_t push_cmd,
    input  logic              pop,
    output ucp_pkg::ucp_cmd_t head,
    output logic              empty,
    output logic              full
);
    import ucp_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    ucp_cmd_t        mem [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CntW'(QUEUE_DEPTH));
    assign head  = mem[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CntW'(1);
        else if (pop && !push)
            count_next = count_reg - CntW'(1);
    end

    // Store requests
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PtrW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            count_reg <= count_next;
        end
    end

endmodule

>>> sv/ucp_back.sv
// Back end: expands each queued request into reply and echo bytes on the output register.
// Depends on ucp_pkg. Drains ucp_queue.
module ucp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ucp_pkg::ucp_cmd_t head,
    input  logic              empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_channel,
    output logic [7:0]        out_byte,
    output logic              out_power,
    output logic              out_last
);
    import ucp_pkg::*;

    logic [2:0] step_reg;
    logic       valid_reg;
    logic       channel_reg;
    logic [7:0] byte_reg;
    logic       power_reg;
    logic       last_reg;

    logic       load;
    logic       final_step;
    logic [2:0] rlen;
    logic       chan_c;
    logic [7:0] byte_c;

    assign rlen       = reply_len(head.reply);
    assign final_step = head.host || (step_reg == rlen);
    assign load       = !empty && (!valid_reg || out_ready);
    assign pop        = load && final_step;

    // Pick the byte for the current step: reply first, then echo
    always_comb
    begin
        if (head.host)
        begin
            chan_c = 1'b1;
            byte_c = head.data;
        end
        else if (step_reg < rlen)
        begin
            chan_c = 1'b1;
            byte_c = reply_char(head.reply, step_reg);
        end
        else
        begin
            chan_c = 1'b0;
            byte_c = head.data;
        end
    end

    // Hold the output register until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
            if (load)
                step_reg <= final_step ? 3'd0 : step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            channel_reg <= chan_c;
            byte_reg    <= byte_c;
            power_reg   <= head.power;
            last_reg    <= final_step;
        end
    end

    assign out_valid   = valid_reg;
    assign out_channel = channel_reg;
    assign out_byte    = byte_reg;
    assign out_power   = power_reg;
    assign out_last    = last_reg;

endmodule

>>> sv/uart_power_command_parser.sv
// Power command parser: link/host byte bridge with "bt:power=on/off" detection.
// Each request passes the queue, then the output register, before it reaches m_tvalid.
// Throughput: one result per cycle from the output register while m_tready is high; a
// host byte gives one result, a link byte its echo after any On or Off reply. A 4-entry
// queue takes input requests every cycle while not full, as earlier replies drain.
// Reset: rst_n asynchronous active low; parser idle, power off, queue and output empty.
module uart_power_command_parser #(
    parameter int LINE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] tx_byte, [8] power_on, [15:9] zero
    output logic        m_tuser,   // [0] channel
    output logic        m_tlast
);
    import ucp_pkg::*;

    `include "uart_power_command_parser_macros.svh"

    logic       q_push;
    logic       q_pop;
    logic       q_empty;
    logic       q_full;
    ucp_cmd_t   push_cmd;
    ucp_cmd_t   head;
    logic [7:0] tx_byte;
    logic       power_on;

    ucp_front #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_source (s_tuser),
        .in_byte   (s_tdata),
        .q_full    (q_full),
        .push      (q_push),
        .push_cmd  (push_cmd)
    );

    ucp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    ucp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (q_empty),
        .pop         (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_channel (m_tuser),
        .out_byte    (tx_byte),
        .out_power   (power_on),
        .out_last    (m_tlast)
    );

    assign m_tdata = {7'b0, power_on, tx_byte};

    // Echo to the host always closes a request
    `UCP_ASSERT_IMP(a_host_echo_last, m_tvalid && !m_tuser, m_tlast, "host echo not last")
    // Only reply bytes precede the final result, and they go to the link
    `UCP_ASSERT_IMP(a_reply_to_link, m_tvalid && !m_tlast, m_tuser, "non-last result to host")
    // A pushed request is present in the queue afterwards
    `UCP_ASSERT_NEXT(a_push_fills, q_push, !q_empty, "queue empty after push")

endmodule
